// ===== rtl/tsmr_pkg.sv =====
package tsmr_pkg;

    localparam int EXP_DEPTH = 1024;
    localparam int IDX_W = $clog2(EXP_DEPTH);
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4228380000;

    localparam int VB_W = 28;
    localparam int K_W = 32;
    localparam int DS_W = 32;
    localparam int U_W = 16;
    localparam int MAG_W = 31;
    localparam int SQ_W = 2 * MAG_W;
    localparam int E_W = 17;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_BEAM_VELOCITY = 2'd0;
    localparam reg_idx_t REG_INV_TWO_VTH_SQ = 2'd1;
    localparam reg_idx_t REG_DENSITY_SCALE = 2'd2;

    typedef logic [E_W-1:0] exp_tab_t [EXP_DEPTH];

    function automatic exp_tab_t build_exp_tab();
        logic [95:0] acc;
        exp_tab_t tab;
        acc = 96'd1 << 32;
        for (int i = 0; i < EXP_DEPTH; i++)
        begin
            tab[i] = E_W'((acc + 96'd32768) >> 16);
            acc = (acc * 96'(EXP_STEP_Q32) + (96'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/two_stream_maxwellian_rejection_trial_core.sv =====
// One rejection-sampling trial per item for a two-beam Maxwellian. Each item
// carries two Q0.16 uniforms; the result is the candidate velocity (signed
// Q16.16), the distribution value density_scale*(e1+e2) saturated to 32 bits,
// and the accept flag. A new item is taken every cycle unless the result side
// stalls; a stall holds the whole pipeline. Each result passes through four
// stages of velocity generation, four of the squared-argument multiply and exp
// table lookup and two of the final scale and compare. The user must write
// configuration registers only while no item is in flight; the core does not enforce it.
module two_stream_maxwellian_rejection_trial_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // uniform_velocity[15:0], uniform_height[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // velocity[31:0], density[63:32], accepted[64], zero pad
);
    import tsmr_pkg::*;

    localparam int LAT = 10;

    logic [VB_W-1:0]   vb_reg;
    logic [K_W-1:0]    k_reg;
    logic [DS_W-1:0]   ds_reg;
    logic [LAT-1:0]    vld_reg;
    logic              adv;

    logic signed [31:0] v_f;
    logic [U_W-1:0]     u2_f;
    logic [MAG_W-1:0]   m1, m2, mp;
    logic [E_W-1:0]     e1, e2, ep;

    logic [31:0]        v_d_reg [4];
    logic [U_W-1:0]     u2_d_reg [4];

    logic [E_W:0]       sum;
    logic [31:0]        v9_reg;
    logic [E_W:0]       sum9_reg;
    logic [DS_W+E_W:0]  dp9_reg;
    logic [U_W+E_W:0]   hp9_reg;
    logic               dsz9_reg;

    logic [31:0]        vo_reg, dens_reg;
    logic               acc_reg;
    logic [DS_W+E_W-16:0] dens_full;

    assign adv = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= VB_W'(65536);
            k_reg  <= K_W'(32768);
            ds_reg <= DS_W'(65536);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_BEAM_VELOCITY:  vb_reg <= cfg_wdata[VB_W-1:0];
                REG_INV_TWO_VTH_SQ: k_reg  <= cfg_wdata;
                REG_DENSITY_SCALE:  ds_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    tsmr_front u_front (
        .clk              (clk),
        .adv              (adv),
        .uniform_velocity (s_tdata[15:0]),
        .uniform_height   (s_tdata[31:16]),
        .beam_velocity    (vb_reg),
        .velocity         (v_f),
        .height           (u2_f),
        .mag_lo           (m1),
        .mag_hi           (m2),
        .mag_peak         (mp)
    );

    tsmr_gauss u_gauss_lo (.clk(clk), .adv(adv), .mag(m1), .inv_two_vth_sq(k_reg), .e(e1));
    tsmr_gauss u_gauss_hi (.clk(clk), .adv(adv), .mag(m2), .inv_two_vth_sq(k_reg), .e(e2));
    tsmr_gauss u_gauss_pk (.clk(clk), .adv(adv), .mag(mp), .inv_two_vth_sq(k_reg), .e(ep));

    always_comb
    begin
        sum = {1'b0, e1} + {1'b0, e2};
        dens_full = dp9_reg[DS_W+E_W:16];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_d_reg[0]  <= v_f;
            u2_d_reg[0] <= u2_f;
            for (int i = 1; i < 4; i++)
            begin
                v_d_reg[i]  <= v_d_reg[i-1];
                u2_d_reg[i] <= u2_d_reg[i-1];
            end
            v9_reg   <= v_d_reg[3];
            sum9_reg <= sum;
            dp9_reg  <= ds_reg * sum;
            hp9_reg  <= u2_d_reg[3] * ({1'b0, ep} + (E_W+1)'(65536));
            dsz9_reg <= (ds_reg == '0);
            vo_reg   <= v9_reg;
            dens_reg <= (|dens_full[DS_W+E_W-16:32]) ? 32'hFFFF_FFFF : dens_full[31:0];
            acc_reg  <= !dsz9_reg && (hp9_reg < {sum9_reg, 16'd0});
        end
    end

    assign m_tdata = {7'd0, acc_reg, dens_reg, vo_reg};

endmodule

// ===== rtl/tsmr_front.sv =====
module tsmr_front (
    input  logic                           clk,
    input  logic                           adv,
    input  logic [tsmr_pkg::U_W-1:0]       uniform_velocity,
    input  logic [tsmr_pkg::U_W-1:0]       uniform_height,
    input  logic [tsmr_pkg::VB_W-1:0]      beam_velocity,
    output logic signed [31:0]             velocity,
    output logic [tsmr_pkg::U_W-1:0]       height,
    output logic [tsmr_pkg::MAG_W-1:0]     mag_lo,
    output logic [tsmr_pkg::MAG_W-1:0]     mag_hi,
    output logic [tsmr_pkg::MAG_W-1:0]     mag_peak
);
    import tsmr_pkg::*;

    logic [U_W-1:0]          u1_reg, u2_a_reg, u2_b_reg, u2_c_reg, u2_d_reg;
    logic [VB_W+U_W-1:0]     prod_reg;
    logic [31:0]             v_reg, v_c_reg;
    logic [MAG_W-1:0]        m1_reg, m2_reg, mp_reg;
    logic [31:0]             v_next;
    logic [32:0]             d1, d2;
    logic [32:0]             a1, a2;

    always_comb
    begin
        v_next = {1'b0, prod_reg[VB_W+U_W-1:13]} - {2'b00, beam_velocity, 2'b00};
        d1 = {v_reg[31], v_reg} - {5'd0, beam_velocity};
        d2 = {v_reg[31], v_reg} + {5'd0, beam_velocity};
        a1 = d1[32] ? (33'd0 - d1) : d1;
        a2 = d2[32] ? (33'd0 - d2) : d2;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u1_reg   <= uniform_velocity;
            u2_a_reg <= uniform_height;
            prod_reg <= beam_velocity * u1_reg;
            u2_b_reg <= u2_a_reg;
            v_reg    <= v_next;
            u2_c_reg <= u2_b_reg;
            v_c_reg  <= v_reg;
            u2_d_reg <= u2_c_reg;
            m1_reg   <= a1[MAG_W-1:0];
            m2_reg   <= a2[MAG_W-1:0];
            mp_reg   <= MAG_W'({beam_velocity, 1'b0});
        end
    end

    assign velocity = v_c_reg;
    assign height   = u2_d_reg;
    assign mag_lo   = m1_reg;
    assign mag_hi   = m2_reg;
    assign mag_peak = mp_reg;

endmodule

// ===== rtl/tsmr_gauss.sv =====
module tsmr_gauss (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [tsmr_pkg::MAG_W-1:0]  mag,
    input  logic [tsmr_pkg::K_W-1:0]    inv_two_vth_sq,
    output logic [tsmr_pkg::E_W-1:0]    e
);
    import tsmr_pkg::*;

    logic [SQ_W-1:0]       sq_reg;
    logic [MAG_W+K_W-1:0]  plo_reg, phi_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  over_reg;
    logic [E_W-1:0]        e_reg;
    logic [63:0]           t;

    always_comb
    begin
        t = 64'(phi_reg) + 64'(plo_reg >> MAG_W);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg   <= mag * mag;
            plo_reg  <= sq_reg[MAG_W-1:0] * inv_two_vth_sq;
            phi_reg  <= sq_reg[SQ_W-1:MAG_W] * inv_two_vth_sq;
            idx_reg  <= t[IDX_W+10:11];
            over_reg <= (t >> 11) >= 64'(EXP_DEPTH);
            e_reg    <= over_reg ? '0 : EXP_TAB[idx_reg];
        end
    end

    assign e = e_reg;

endmodule

// ===== sim/two_stream_maxwellian_rejection_trial_checker.sv =====
module two_stream_maxwellian_rejection_trial_checker
    import tsmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed
    {
        logic [31:0] velocity;
        logic [31:0] density;
        logic        accepted;
    } trial_result_t;

    logic [E_W-1:0] exp_lut [EXP_DEPTH];
    logic [VB_W-1:0] beam_vel;
    logic [K_W-1:0] inv_k;
    logic [DS_W-1:0] dens_scale;
    trial_result_t expected_results [$];

    initial
    begin
        logic [95:0] acc;
        acc = 96'd1 << 32;
        for (int i = 0; i < EXP_DEPTH; i++)
        begin
            exp_lut[i] = E_W'((acc + 96'd32768) >> 16);
            acc = (acc * 96'd4228380000 + (96'd1 << 31)) >> 32;
        end
        fail_count = 0;
    end

    function automatic logic [E_W-1:0] gauss(logic signed [63:0] x);
        logic [127:0] prod;
        logic [127:0] idx;
        logic [63:0] mag;
        mag = x < 0 ? 64'(-x) : 64'(x);
        prod = 128'(mag) * 128'(mag);
        prod = prod * 128'(inv_k);
        idx = prod >> 42;
        if (idx >= EXP_DEPTH)
            return '0;
        return exp_lut[idx[IDX_W-1:0]];
    endfunction

    function automatic trial_result_t predict_trial(logic [15:0] u1, logic [15:0] u2);
        trial_result_t r;
        logic signed [63:0] vb;
        logic signed [63:0] v;
        logic [63:0] sum;
        logic [63:0] dens;
        logic [63:0] ep;
        vb = 64'(beam_vel);
        v = -4 * vb + 64'((64'(beam_vel) * 64'd8 * 64'(u1)) >> 16);
        sum = 64'(gauss(v - vb)) + 64'(gauss(v + vb));
        ep = 64'(gauss(2 * vb));
        dens = (64'(dens_scale) * sum) >> 16;
        r.velocity = v[31:0];
        r.density = dens > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : dens[31:0];
        r.accepted = dens_scale != 0 && 64'(u2) * (64'd65536 + ep) < sum * 64'd65536;
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        trial_result_t want;
        trial_result_t got;
        if (!rst_n)
        begin
            beam_vel <= 28'd65536;
            inv_k <= 32'd32768;
            dens_scale <= 32'd65536;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_BEAM_VELOCITY:  beam_vel <= cfg_wdata[VB_W-1:0];
                    REG_INV_TWO_VTH_SQ: inv_k <= cfg_wdata;
                    REG_DENSITY_SCALE:  dens_scale <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_trial(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[64]};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected item: velocity %h density %h accepted %b",
                                 got.velocity, got.density, got.accepted);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: velocity %h/%h density %h/%h accepted %b/%b",
                                     want.velocity, got.velocity, want.density,
                                     got.density, want.accepted, got.accepted);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/two_stream_maxwellian_rejection_trial_core_tb.sv =====
module two_stream_maxwellian_rejection_trial_core_tb;
    import tsmr_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    int          fail_count;
    int          pending;
    int          trials_sent = 0;
    int          trials_seen = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    bit          long_hold = 1'b0;

    always #6 clk = ~clk;

    two_stream_maxwellian_rejection_trial_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    two_stream_maxwellian_rejection_trial_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            trials_seen++;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 4000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random back-pressure, one long hold on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_trial(logic [15:0] u1, logic [15:0] u2);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {u2, u1};
        do @(posedge clk); while (!s_tready);
        trials_sent++;
    endtask

    function automatic logic [15:0] pick_uniform();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_trials(int count);
        for (int i = 0; i < count; i++)
            send_trial(pick_uniform(), pick_uniform());
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (trials_seen != trials_sent)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] directed_u1 [10] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF,
                                          16'h4000, 16'hC000, 16'h8000, 16'h2000, 16'h6000};
        logic [15:0] directed_u2 [10] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                                          16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'hFFFE};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 10; i++)
            send_trial(directed_u1[i], directed_u2[i]);
        run_trials(200);

        write_reg(REG_BEAM_VELOCITY, 32'd0);
        run_trials(150);

        write_reg(REG_BEAM_VELOCITY, 32'hFFFF_FFFF);
        write_reg(REG_INV_TWO_VTH_SQ, 32'hFFFF_FFFF);
        write_reg(REG_DENSITY_SCALE, 32'hFFFF_FFFF);
        run_trials(150);

        write_reg(REG_BEAM_VELOCITY, 32'd131072);
        write_reg(REG_INV_TWO_VTH_SQ, 32'd32768);
        write_reg(REG_DENSITY_SCALE, 32'd0);
        run_trials(150);

        write_reg(REG_BEAM_VELOCITY, 32'd65536);
        write_reg(REG_INV_TWO_VTH_SQ, 32'd0);
        write_reg(REG_DENSITY_SCALE, 32'hFFFF_FFFF);
        run_trials(150);

        write_reg(REG_BEAM_VELOCITY, 32'd98304);
        write_reg(REG_INV_TWO_VTH_SQ, 32'd65536);
        write_reg(REG_DENSITY_SCALE, 32'd196608);
        write_reg(2'd3, 32'hDEAD_BEEF);
        long_hold = 1'b1;
        run_trials(250);

        for (int p = 0; p < 3; p++)
        begin
            write_reg(REG_BEAM_VELOCITY, $urandom_range(0, 32'h0004_0000));
            write_reg(REG_INV_TWO_VTH_SQ, $urandom);
            write_reg(REG_DENSITY_SCALE, $urandom);
            run_trials(250);
        end

        calm = 1'b1;
        write_reg(REG_BEAM_VELOCITY, 32'd65536);
        write_reg(REG_INV_TWO_VTH_SQ, 32'd16384);
        write_reg(REG_DENSITY_SCALE, $urandom);
        run_trials(250);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tsmr_pkg.sv
rtl/tsmr_front.sv
rtl/tsmr_gauss.sv
rtl/two_stream_maxwellian_rejection_trial_core.sv
sim/two_stream_maxwellian_rejection_trial_checker.sv
sim/two_stream_maxwellian_rejection_trial_core_tb.sv
